>>> sv/mlr_pkg.sv
// Package for the matrix line rotator: field widths, command and register codes,
// and the command and status structs that pass between controller and datapath.
// It depends on nothing.
package mlr_pkg;

    localparam int MAX_DIM_DEFAULT = 32;
    localparam int DATA_W          = 32;
    localparam int IDX_IN_W        = 5;
    localparam int AMOUNT_W        = 10;
    localparam int CFG_W           = 6;
    localparam int CFG_INDEX_W     = 1;
    localparam int MOD_CNT_W       = $clog2(AMOUNT_W);
    localparam logic [CFG_W-1:0] SIZE_RESET = CFG_W'(32);

    typedef enum logic [1:0] {
        CMD_WRITE = 2'd0,
        CMD_READ  = 2'd1,
        CMD_ROW   = 2'd2,
        CMD_COL   = 2'd3
    } op_t;

    localparam logic [CFG_INDEX_W-1:0] REG_NUM_ROWS = CFG_INDEX_W'(0);
    localparam logic [CFG_INDEX_W-1:0] REG_NUM_COLS = CFG_INDEX_W'(1);

    typedef struct packed {
        logic capture;
        logic write_elem;
        logic read_elem;
        logic take_read;
        logic mod_start;
        logic mod_step;
        logic load_step;
        logic store_init;
        logic store_step;
        logic out_load;
    } mlr_cmd_t;

    typedef struct packed {
        op_t  op;
        logic err;
        logic mod_last;
        logic load_last;
        logic store_last;
        logic out_free;
    } mlr_stat_t;

endpackage

>>> sv/mlr_ram.sv
// Generic single-port-write, single-port-read RAM with a registered read.
// It depends on nothing.
module mlr_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

>>> sv/mlr_ctrl.sv
// Controller state machine of the matrix line rotator.
// It depends on mlr_pkg and drives the datapath by command and status structs.
module mlr_ctrl (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  mlr_pkg::mlr_stat_t stat,
    output mlr_pkg::mlr_cmd_t  cmd
);
    import mlr_pkg::*;

    typedef enum logic [8:0] {
        ST_IDLE     = 9'b000000001,
        ST_DECODE   = 9'b000000010,
        ST_RDWAIT   = 9'b000000100,
        ST_MOD      = 9'b000001000,
        ST_LOAD     = 9'b000010000,
        ST_LOADEND  = 9'b000100000,
        ST_STORE    = 9'b001000000,
        ST_STOREEND = 9'b010000000,
        ST_DONE     = 9'b100000000
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.capture = 1'b1;
                    state_next  = ST_DECODE;
                end
            end
            ST_DECODE:
            begin
                if (stat.err)
                begin
                    state_next = ST_DONE;
                end
                else
                begin
                    case (stat.op)
                        CMD_WRITE:
                        begin
                            cmd.write_elem = 1'b1;
                            state_next     = ST_DONE;
                        end
                        CMD_READ:
                        begin
                            cmd.read_elem = 1'b1;
                            state_next    = ST_RDWAIT;
                        end
                        default:
                        begin
                            cmd.mod_start = 1'b1;
                            state_next    = ST_MOD;
                        end
                    endcase
                end
            end
            ST_RDWAIT:
            begin
                cmd.take_read = 1'b1;
                state_next    = ST_DONE;
            end
            ST_MOD:
            begin
                cmd.mod_step = 1'b1;
                if (stat.mod_last)
                begin
                    state_next = ST_LOAD;
                end
            end
            ST_LOAD:
            begin
                cmd.load_step = 1'b1;
                if (stat.load_last)
                begin
                    state_next = ST_LOADEND;
                end
            end
            ST_LOADEND:
            begin
                cmd.store_init = 1'b1;
                state_next     = ST_STORE;
            end
            ST_STORE:
            begin
                cmd.store_step = 1'b1;
                if (stat.store_last)
                begin
                    state_next = ST_STOREEND;
                end
            end
            ST_STOREEND:
            begin
                state_next = ST_DONE;
            end
            ST_DONE:
            begin
                if (stat.out_free)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

>>> sv/mlr_datapath.sv
// Datapath of the matrix line rotator: size registers, item registers, modulo unit,
// line counters, matrix store and line buffer, and the output register.
// It depends on mlr_pkg and mlr_ram.
module mlr_datapath #(
    parameter int MAX_DIM = mlr_pkg::MAX_DIM_DEFAULT
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  mlr_pkg::mlr_cmd_t                    cmd,
    output mlr_pkg::mlr_stat_t                   stat,
    input  logic [1:0]                           command,
    input  logic [mlr_pkg::IDX_IN_W-1:0]         row_index,
    input  logic [mlr_pkg::IDX_IN_W-1:0]         col_index,
    input  logic                                 toward_lower,
    input  logic [mlr_pkg::AMOUNT_W-1:0]         amount,
    input  logic signed [mlr_pkg::DATA_W-1:0]    write_value,
    input  logic                                 cfg_valid,
    input  logic [mlr_pkg::CFG_INDEX_W-1:0]      cfg_index,
    input  logic [mlr_pkg::CFG_W-1:0]            cfg_data,
    input  logic                                 out_ready,
    output logic                                 out_valid,
    output logic signed [mlr_pkg::DATA_W-1:0]    read_value,
    output logic                                 error
);
    import mlr_pkg::*;

    localparam int IDX_W  = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;
    localparam int SIZE_W = $clog2(MAX_DIM + 1);
    localparam int ADDR_W = 2 * IDX_W;
    localparam int LINE_D = 1 << IDX_W;
    localparam int MAT_D  = 1 << ADDR_W;

    function automatic logic [SIZE_W-1:0] eff_size(input logic [CFG_W-1:0] r);
        logic [SIZE_W-1:0] s;
        if (r == '0)
            s = SIZE_W'(1);
        else if (32'(r) > MAX_DIM)
            s = SIZE_W'(MAX_DIM);
        else
            s = SIZE_W'(r);
        return s;
    endfunction

    logic [CFG_W-1:0]           rows_cfg_reg;
    logic [CFG_W-1:0]           cols_cfg_reg;
    op_t                        op_reg;
    logic [IDX_IN_W-1:0]        row_reg;
    logic [IDX_IN_W-1:0]        col_reg;
    logic                       tl_reg;
    logic [AMOUNT_W-1:0]        amt_reg;
    logic [DATA_W-1:0]          wval_reg;
    logic [SIZE_W-1:0]          rem_reg;
    logic [SIZE_W-1:0]          rem_next;
    logic [MOD_CNT_W-1:0]       mod_cnt_reg;
    logic [IDX_W-1:0]           cnt_reg;
    logic [IDX_W-1:0]           src_reg;
    logic [IDX_W-1:0]           src_start;
    logic                       lpend_reg;
    logic [IDX_W-1:0]           lpend_idx_reg;
    logic                       spend_reg;
    logic [IDX_W-1:0]           spend_idx_reg;
    logic [DATA_W-1:0]          rval_reg;
    logic                       out_valid_reg;
    logic [DATA_W-1:0]          read_value_reg;
    logic                       error_reg;

    logic [SIZE_W-1:0]          rows;
    logic [SIZE_W-1:0]          cols;
    logic [SIZE_W-1:0]          len;
    logic [SIZE_W:0]            rem_shift;
    logic                       row_ok;
    logic                       col_ok;
    logic                       err;
    logic                       cnt_last;
    logic [IDX_W-1:0]           row_i;
    logic [IDX_W-1:0]           col_i;
    logic [ADDR_W-1:0]          elem_addr;
    logic [ADDR_W-1:0]          load_addr;
    logic [ADDR_W-1:0]          store_addr;

    logic                       mat_we;
    logic [ADDR_W-1:0]          mat_waddr;
    logic [DATA_W-1:0]          mat_wdata;
    logic [ADDR_W-1:0]          mat_raddr;
    logic [DATA_W-1:0]          mat_rdata;
    logic [DATA_W-1:0]          lb_rdata;

    assign rows   = eff_size(rows_cfg_reg);
    assign cols   = eff_size(cols_cfg_reg);
    assign len    = (op_reg == CMD_ROW) ? cols : rows;
    assign row_ok = 32'(row_reg) < 32'(rows);
    assign col_ok = 32'(col_reg) < 32'(cols);
    assign row_i  = IDX_W'(32'(row_reg));
    assign col_i  = IDX_W'(32'(col_reg));

    always_comb
    begin
        case (op_reg)
            CMD_ROW: err = !row_ok;
            CMD_COL: err = !col_ok;
            default: err = !(row_ok && col_ok);
        endcase
    end

    assign elem_addr  = {row_i, col_i};
    assign load_addr  = (op_reg == CMD_ROW) ? {row_i, cnt_reg} : {cnt_reg, col_i};
    assign store_addr = (op_reg == CMD_ROW) ? {row_i, spend_idx_reg}
                                            : {spend_idx_reg, col_i};
    assign cnt_last   = 32'(cnt_reg) == 32'(len) - 1;

    assign rem_shift = {rem_reg, amt_reg[AMOUNT_W-1]};
    always_comb
    begin
        if (rem_shift >= {1'b0, len})
            rem_next = SIZE_W'(rem_shift - {1'b0, len});
        else
            rem_next = SIZE_W'(rem_shift);
    end

    always_comb
    begin
        if (tl_reg)
            src_start = IDX_W'(rem_reg);
        else if (rem_reg == '0)
            src_start = '0;
        else
            src_start = IDX_W'(len - rem_reg);
    end

    assign mat_we    = cmd.write_elem || spend_reg;
    assign mat_waddr = cmd.write_elem ? elem_addr : store_addr;
    assign mat_wdata = cmd.write_elem ? wval_reg : lb_rdata;
    assign mat_raddr = cmd.read_elem ? elem_addr : load_addr;

    mlr_ram #(
        .WIDTH (DATA_W),
        .DEPTH (MAT_D)
    ) u_matrix (
        .clk   (clk),
        .we    (mat_we),
        .waddr (mat_waddr),
        .wdata (mat_wdata),
        .raddr (mat_raddr),
        .rdata (mat_rdata)
    );

    mlr_ram #(
        .WIDTH (DATA_W),
        .DEPTH (LINE_D)
    ) u_line (
        .clk   (clk),
        .we    (lpend_reg),
        .waddr (lpend_idx_reg),
        .wdata (mat_rdata),
        .raddr (src_reg),
        .rdata (lb_rdata)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rows_cfg_reg  <= SIZE_RESET;
            cols_cfg_reg  <= SIZE_RESET;
            mod_cnt_reg   <= '0;
            cnt_reg       <= '0;
            lpend_reg     <= 1'b0;
            spend_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_valid)
            begin
                case (cfg_index)
                    REG_NUM_ROWS: rows_cfg_reg <= cfg_data;
                    REG_NUM_COLS: cols_cfg_reg <= cfg_data;
                    default:
                    begin
                    end
                endcase
            end
            if (cmd.mod_start)
            begin
                mod_cnt_reg <= '0;
                cnt_reg     <= '0;
            end
            else if (cmd.mod_step)
            begin
                mod_cnt_reg <= mod_cnt_reg + 1'b1;
            end
            else if (cmd.store_init)
            begin
                cnt_reg <= '0;
            end
            else if (cmd.load_step || cmd.store_step)
            begin
                cnt_reg <= cnt_reg + 1'b1;
            end
            lpend_reg <= cmd.load_step;
            spend_reg <= cmd.store_step;
            if (cmd.out_load)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            op_reg   <= op_t'(command);
            row_reg  <= row_index;
            col_reg  <= col_index;
            tl_reg   <= toward_lower;
            amt_reg  <= amount;
            wval_reg <= $unsigned(write_value);
        end
        else if (cmd.mod_step)
        begin
            amt_reg <= {amt_reg[AMOUNT_W-2:0], 1'b0};
        end
        if (cmd.mod_start)
            rem_reg <= '0;
        else if (cmd.mod_step)
            rem_reg <= rem_next;
        if (cmd.store_init)
            src_reg <= src_start;
        else if (cmd.store_step)
            src_reg <= (32'(src_reg) == 32'(len) - 1) ? '0 : src_reg + 1'b1;
        lpend_idx_reg <= cnt_reg;
        spend_idx_reg <= cnt_reg;
        if (cmd.take_read)
            rval_reg <= mat_rdata;
        if (cmd.out_load)
        begin
            read_value_reg <= (op_reg == CMD_READ && !err) ? rval_reg : '0;
            error_reg      <= err;
        end
    end

    assign stat.op         = op_reg;
    assign stat.err        = err;
    assign stat.mod_last   = mod_cnt_reg == MOD_CNT_W'(AMOUNT_W - 1);
    assign stat.load_last  = cnt_last;
    assign stat.store_last = cnt_last;
    assign stat.out_free   = !out_valid_reg || out_ready;

    assign out_valid  = out_valid_reg;
    assign read_value = $signed(read_value_reg);
    assign error      = error_reg;

endmodule

>>> sv/matrix_line_rotator_core.sv
// Top level of the matrix line rotator: controller and datapath joined by structs.
// It depends on mlr_pkg, mlr_ctrl, mlr_datapath and mlr_ram.
//
// The block holds a matrix of signed 32-bit words and takes one command per
// input transfer: write an element, read an element, or rotate a row or a
// column circularly by an amount reduced modulo the line length. Every input
// transfer gives exactly one output transfer carrying read_value and error.
// The size registers num_rows (index 0) and num_cols (index 1) are written on
// the configuration channel, which is always ready; write them only while the
// block is idle.
// One item is worked on at a time. A write is stored in the decode state, a read
// waits for the registered memory read, and a rotation of a line of length L
// runs a bit-serial modulo reduction over the 10 bits of the amount, reads the
// L words of the line out of the matrix memory into the line buffer, and writes
// them back through the line buffer's read port. An item with an error goes from
// decoding straight to the result.
// The output register lets the next input transfer be accepted while a result
// waits; if the receiver stalls, the following item finishes and then holds in
// the controller until the output register is free.
// Reset clears the control state and sets both sizes to 32; the matrix memory
// is not cleared and must be written before it is read.
module matrix_line_rotator_core #(
    parameter int MAX_DIM = mlr_pkg::MAX_DIM_DEFAULT
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 in_valid,
    output logic                                 in_ready,
    input  logic [1:0]                           command,
    input  logic [mlr_pkg::IDX_IN_W-1:0]         row_index,
    input  logic [mlr_pkg::IDX_IN_W-1:0]         col_index,
    input  logic                                 toward_lower,
    input  logic [mlr_pkg::AMOUNT_W-1:0]         amount,
    input  logic signed [mlr_pkg::DATA_W-1:0]    write_value,
    output logic                                 out_valid,
    input  logic                                 out_ready,
    output logic signed [mlr_pkg::DATA_W-1:0]    read_value,
    output logic                                 error,
    input  logic                                 cfg_valid,
    output logic                                 cfg_ready,
    input  logic [mlr_pkg::CFG_INDEX_W-1:0]      cfg_index,
    input  logic [mlr_pkg::CFG_W-1:0]            cfg_data
);
    import mlr_pkg::*;

    mlr_cmd_t  cmd;
    mlr_stat_t stat;

    assign cfg_ready = 1'b1;

    mlr_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .stat     (stat),
        .cmd      (cmd)
    );

    mlr_datapath #(
        .MAX_DIM (MAX_DIM)
    ) u_datapath (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .stat         (stat),
        .command      (command),
        .row_index    (row_index),
        .col_index    (col_index),
        .toward_lower (toward_lower),
        .amount       (amount),
        .write_value  (write_value),
        .cfg_valid    (cfg_valid),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .out_ready    (out_ready),
        .out_valid    (out_valid),
        .read_value   (read_value),
        .error        (error)
    );

endmodule

>>> sv/mlr_checker.sv
// Port-level checker for the matrix line rotator and the bind that attaches it.
// It depends on mlr_pkg and on the port names of matrix_line_rotator_core.
module mlr_checker (
    input logic                              clk,
    input logic                              rst_n,
    input logic                              in_valid,
    input logic                              in_ready,
    input logic                              out_valid,
    input logic                              out_ready,
    input logic signed [mlr_pkg::DATA_W-1:0] read_value,
    input logic                              error
);

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(read_value) && $stable(error))
        else $error("A stalled result transfer changed or was dropped.");

    a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("A second item was accepted while one was at work.");

    a_error_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && error |-> read_value == '0)
        else $error("A result with an error carried a non-zero value.");

endmodule

bind matrix_line_rotator_core mlr_checker u_checker (.*);
